### rtl/core/threshold_median3x3_filter_unit_defines.svh
// Assertion helpers for the filter unit.
`ifndef THRESHOLD_MEDIAN3X3_FILTER_UNIT_DEFINES_SVH
`define THRESHOLD_MEDIAN3X3_FILTER_UNIT_DEFINES_SVH

// Implication checked at every edge outside reset.
`define TMF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked at every edge, reset included.
`define TMF_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/tmf_pkg.sv
`default_nettype none

package tmf_pkg;

   localparam int SAMPLE_W          = 8;
   localparam int WIDTH_W           = 12;
   localparam int HEIGHT_W          = 16;
   localparam int THRESH_W          = 8;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 16;
   localparam int MAX_WIDTH_DEFAULT = 2048;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH       = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT      = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACE_THRESHOLD = CSR_INDEX_W'(2);

   localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RESET       = WIDTH_W'(2048);
   localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RESET      = HEIGHT_W'(1);
   localparam logic [THRESH_W-1:0] REPLACE_THRESHOLD_RESET = THRESH_W'(1);

   typedef logic [SAMPLE_W-1:0] sample_type;
   // [0] red, [1] green, [2] blue
   typedef sample_type [2:0] pixel_type;
   // [row][column], row 0 is the oldest line
   typedef pixel_type [2:0][2:0] window_type;

   typedef struct packed {
      logic last;
      logic eor;
      logic eof;
   } tag_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
      logic      first_col;
      logic      has_a;
      logic      has_b;
      logic      row_end;
      logic      eof;
   } column_beat_type;

   typedef struct packed {
      window_type taps;
      tag_type    tag;
   } tap_beat_type;

   function automatic sample_type min2(input sample_type a, input sample_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic sample_type max2(input sample_type a, input sample_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic sample_type min3(input sample_type a, input sample_type b,
                                       input sample_type c);
      return min2(min2(a, b), c);
   endfunction

   function automatic sample_type max3(input sample_type a, input sample_type b,
                                       input sample_type c);
      return max2(max2(a, b), c);
   endfunction

   function automatic sample_type med3(input sample_type a, input sample_type b,
                                       input sample_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

`default_nettype wire

### rtl/core/tmf_req_if.sv
`default_nettype none

interface tmf_req_if;
   import tmf_pkg::*;

   logic       valid;
   logic       ready;
   logic       action;
   sample_type red_in;
   sample_type green_in;
   sample_type blue_in;

   modport source (output valid, action, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

`default_nettype wire

### rtl/core/tmf_rsp_if.sv
`default_nettype none

interface tmf_rsp_if;
   import tmf_pkg::*;

   logic       valid;
   logic       ready;
   sample_type red_out;
   sample_type green_out;
   sample_type blue_out;
   logic       last_of_run;
   logic       end_of_row;
   logic       end_of_frame;

   modport source (output valid, red_out, green_out, blue_out, last_of_run, end_of_row,
                   end_of_frame, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, last_of_run, end_of_row,
                   end_of_frame, output ready);
endinterface

`default_nettype wire

### rtl/core/tmf_line_buffer.sv
`default_nettype none

module tmf_line_buffer #(
   parameter int MAX_WIDTH = tmf_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tmf_req_if.sink                            req_if,
   input  wire logic [tmf_pkg::WIDTH_W-1:0]   image_width,
   input  wire logic [tmf_pkg::HEIGHT_W-1:0]  image_height,
   output tmf_pkg::column_beat_type           beat,
   output logic                               beat_valid,
   input  wire logic                          beat_take
);
   import tmf_pkg::*;

   localparam int ColW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int CmpW = ((ColW > WIDTH_W) ? ColW : WIDTH_W) + 1;

   logic [ColW-1:0]     col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [CmpW-1:0]     width_lim, width_eff;
   logic [HEIGHT_W-1:0] height_eff;
   logic                row_end, frame_end, accept;

   pixel_type upper_mem [MAX_WIDTH];
   pixel_type middle_mem [MAX_WIDTH];
   pixel_type upper_rd_ff, middle_rd_ff;

   logic            s1_valid_ff, s1_valid_in;
   logic [ColW-1:0] addr_ff;
   logic            drain_ff, first_row_ff, first_col_ff;
   logic            has_a_ff, has_b_ff, row_end_ff, eof_ff;
   pixel_type       pixel_ff;
   pixel_type       pix, upper_wr;

   assign width_lim  = (CmpW'(image_width) > CmpW'(MAX_WIDTH)) ? CmpW'(MAX_WIDTH)
                                                               : CmpW'(image_width);
   assign width_eff  = (width_lim < CmpW'(2)) ? CmpW'(2) : width_lim;
   assign height_eff = (image_height == '0) ? HEIGHT_W'(1) : image_height;
   assign row_end    = CmpW'(col_ff) >= (width_eff - CmpW'(1));
   assign frame_end  = row_ff >= height_eff;

   assign req_if.ready = !s1_valid_ff || beat_take;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + HEIGHT_W'(1);
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (beat_take ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff      <= col_ff;
         drain_ff     <= req_if.action;
         pixel_ff     <= {req_if.blue_in, req_if.green_in, req_if.red_in};
         first_row_ff <= (row_ff == '0);
         first_col_ff <= (col_ff == '0);
         has_a_ff     <= (row_ff != '0) && (col_ff != '0);
         has_b_ff     <= (row_ff != '0) && row_end;
         row_end_ff   <= row_end;
         eof_ff       <= frame_end;
      end
   end

   // Consecutive transactions never share a column, so the read issued here
   // never collides with the write-back of the transaction ahead of it.
   always_ff @(posedge clock) begin
      if (beat_take) begin
         upper_mem[addr_ff] <= upper_wr;
      end
      if (accept) begin
         upper_rd_ff <= upper_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (beat_take) begin
         middle_mem[addr_ff] <= pix;
      end
      if (accept) begin
         middle_rd_ff <= middle_mem[col_ff];
      end
   end

   // drain beats replay the middle line
   assign pix      = drain_ff ? middle_rd_ff : pixel_ff;
   assign upper_wr = first_row_ff ? pix : middle_rd_ff;

   always_comb begin
      beat.top       = first_row_ff ? pix : upper_rd_ff;
      beat.mid       = upper_wr;
      beat.bot       = pix;
      beat.first_col = first_col_ff;
      beat.has_a     = has_a_ff;
      beat.has_b     = has_b_ff;
      beat.row_end   = row_end_ff;
      beat.eof       = eof_ff;
   end

   assign beat_valid = s1_valid_ff;

endmodule

`default_nettype wire

### rtl/core/tmf_window.sv
`default_nettype none

module tmf_window (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tmf_pkg::column_beat_type beat,
   input  wire logic             beat_valid,
   output logic                  beat_take,
   output tmf_pkg::tap_beat_type tap,
   output logic                  tap_valid,
   input  wire logic             tap_ready
);
   import tmf_pkg::*;

   window_type win_ff, win_in;
   logic       pend_a_ff, pend_a_in, pend_b_ff, pend_b_in;
   logic       row_end_ff, eof_ff;
   logic       emit, use_b, finish;
   pixel_type  col_new [3];

   assign tap_valid = pend_a_ff || pend_b_ff;
   assign emit      = tap_valid && tap_ready;
   assign use_b     = !pend_a_ff;
   assign finish    = emit && (use_b || !pend_b_ff);
   assign beat_take = beat_valid && (!tap_valid || finish);

   assign col_new[0] = beat.top;
   assign col_new[1] = beat.mid;
   assign col_new[2] = beat.bot;

   always_comb begin
      win_in = win_ff;
      if (beat_take) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = beat.first_col ? col_new[r] : win_ff[r][2];
            win_in[r][2] = col_new[r];
         end
      end
   end

   always_comb begin
      pend_a_in = pend_a_ff;
      pend_b_in = pend_b_ff;
      if (beat_take) begin
         pend_a_in = beat.has_a;
         pend_b_in = beat.has_b;
      end else if (emit) begin
         if (use_b) begin
            pend_b_in = 1'b0;
         end else begin
            pend_a_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff    <= '0;
         pend_a_ff <= 1'b0;
         pend_b_ff <= 1'b0;
      end else begin
         win_ff    <= win_in;
         pend_a_ff <= pend_a_in;
         pend_b_ff <= pend_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_take) begin
         row_end_ff <= beat.row_end;
         eof_ff     <= beat.eof;
      end
   end

   // Row-end result replicates the right border column.
   always_comb begin
      tap.taps = win_ff;
      tap.tag  = '{last: !row_end_ff, eor: 1'b0, eof: 1'b0};
      if (use_b) begin
         for (int r = 0; r < 3; r++) begin
            tap.taps[r][0] = win_ff[r][1];
            tap.taps[r][1] = win_ff[r][2];
            tap.taps[r][2] = win_ff[r][2];
         end
         tap.tag = '{last: 1'b1, eor: 1'b1, eof: eof_ff};
      end
   end

endmodule

`default_nettype wire

### rtl/core/tmf_median.sv
`default_nettype none

module tmf_median (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tmf_pkg::tap_beat_type        tap,
   input  wire logic                         tap_valid,
   output logic                              tap_ready,
   input  wire logic [tmf_pkg::THRESH_W-1:0] replace_threshold,
   tmf_rsp_if.source                         rsp_if
);
   import tmf_pkg::*;

   // stage 3: each column sorted
   pixel_type [2:0] lo_ff, md_ff, hi_ff, lo_in, md_in, hi_in;
   pixel_type       s3_centre_ff;
   tag_type         s3_tag_ff;
   logic            s3_valid_ff, s3_valid_in;

   // stage 4: median candidates
   pixel_type a_ff, b_ff, c_ff, a_in, b_in, c_in;
   pixel_type s4_centre_ff;
   tag_type   s4_tag_ff;
   logic      s4_valid_ff, s4_valid_in;

   // result register
   pixel_type res_ff, res_in;
   tag_type   res_tag_ff;
   logic      out_valid_ff, out_valid_in;

   logic out_free, s4_free, s3_free, s3_load, s3_move, s4_move;

   assign out_free  = !out_valid_ff || rsp_if.ready;
   assign s4_free   = !s4_valid_ff || out_free;
   assign s3_free   = !s3_valid_ff || s4_free;
   assign s4_move   = s4_valid_ff && out_free;
   assign s3_move   = s3_valid_ff && s4_free;
   assign tap_ready = s3_free;
   assign s3_load   = tap_valid && s3_free;

   assign s3_valid_in  = s3_load ? 1'b1 : (s3_move ? 1'b0 : s3_valid_ff);
   assign s4_valid_in  = s3_move ? 1'b1 : (s4_move ? 1'b0 : s4_valid_ff);
   assign out_valid_in = s4_move ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);

   always_comb begin
      for (int col = 0; col < 3; col++) begin
         for (int ch = 0; ch < 3; ch++) begin
            lo_in[col][ch] = min3(tap.taps[0][col][ch], tap.taps[1][col][ch],
                                  tap.taps[2][col][ch]);
            md_in[col][ch] = med3(tap.taps[0][col][ch], tap.taps[1][col][ch],
                                  tap.taps[2][col][ch]);
            hi_in[col][ch] = max3(tap.taps[0][col][ch], tap.taps[1][col][ch],
                                  tap.taps[2][col][ch]);
         end
      end
   end

   // median of nine = med3(max of lows, med of mids, min of highs)
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         a_in[ch] = max3(lo_ff[0][ch], lo_ff[1][ch], lo_ff[2][ch]);
         b_in[ch] = med3(md_ff[0][ch], md_ff[1][ch], md_ff[2][ch]);
         c_in[ch] = min3(hi_ff[0][ch], hi_ff[1][ch], hi_ff[2][ch]);
      end
   end

   always_comb begin
      sample_type med;
      sample_type diff;
      for (int ch = 0; ch < 3; ch++) begin
         med  = med3(a_ff[ch], b_ff[ch], c_ff[ch]);
         diff = (s4_centre_ff[ch] > med) ? s4_centre_ff[ch] - med
                                         : med - s4_centre_ff[ch];
         res_in[ch] = (diff > replace_threshold) ? med : s4_centre_ff[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_load) begin
         lo_ff        <= lo_in;
         md_ff        <= md_in;
         hi_ff        <= hi_in;
         s3_centre_ff <= tap.taps[1][1];
         s3_tag_ff    <= tap.tag;
      end
      if (s3_move) begin
         a_ff         <= a_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         s4_centre_ff <= s3_centre_ff;
         s4_tag_ff    <= s3_tag_ff;
      end
      if (s4_move) begin
         res_ff     <= res_in;
         res_tag_ff <= s4_tag_ff;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.red_out      = res_ff[0];
   assign rsp_if.green_out    = res_ff[1];
   assign rsp_if.blue_out     = res_ff[2];
   assign rsp_if.last_of_run  = res_tag_ff.last;
   assign rsp_if.end_of_row   = res_tag_ff.eor;
   assign rsp_if.end_of_frame = res_tag_ff.eof;

endmodule

`default_nettype wire

### rtl/core/threshold_median3x3_filter_unit.sv
// Switching 3x3 median filter for an RGB pixel stream.
// req_if takes one transaction per pixel in raster order (action 0), or a
// drain beat (action 1) that replays the last row; width drains flush a frame.
// rsp_if returns filtered pixels one row and one pixel behind the input: no
// results in a frame's first row or at column 0, one per middle column and
// two at the last column of a row (the second flagged end_of_row).
// Configuration is written through csr_we/csr_index/csr_wdata; the user must
// write it only while idle, which the block itself does not enforce.
// Each pixel passes the line-buffer register, the window, stage 3, stage 4 and
// the result register; the row-end second result follows the first.
// Throughput: one pixel per cycle while rsp_if takes results, with one read
// and one write per line store each cycle; at each row end after a frame's
// first row the input holds while the window emits both results.
// Reset clears the counters, window and pipeline valids and restores the
// register defaults; line stores hold garbage until the first row writes them.
// When rsp_if stalls, the pipeline fills behind the output register and
// req_if.ready drops once all stages are full; nothing is lost.
`default_nettype none

`include "threshold_median3x3_filter_unit_defines.svh"

module threshold_median3x3_filter_unit #(
   parameter int MAX_WIDTH = tmf_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tmf_req_if.sink                              req_if,
   tmf_rsp_if.source                            rsp_if,
   input  wire logic                            csr_we,
   input  wire logic [tmf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tmf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tmf_pkg::*;

   logic [WIDTH_W-1:0]  image_width_ff;
   logic [HEIGHT_W-1:0] image_height_ff;
   logic [THRESH_W-1:0] replace_threshold_ff;

   column_beat_type line_beat;
   logic            line_valid, line_take;
   tap_beat_type    tap;
   logic            tap_valid, tap_ready;
   logic            eof_shown, row_closed, second_taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff       <= IMAGE_WIDTH_RESET;
         image_height_ff      <= IMAGE_HEIGHT_RESET;
         replace_threshold_ff <= REPLACE_THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[WIDTH_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[HEIGHT_W-1:0];
            end
            CSR_REPLACE_THRESHOLD: begin
               replace_threshold_ff <= csr_wdata[THRESH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   tmf_line_buffer #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .beat         (line_beat),
      .beat_valid   (line_valid),
      .beat_take    (line_take)
   );

   tmf_window u_window (
      .clock      (clock),
      .reset      (reset),
      .beat       (line_beat),
      .beat_valid (line_valid),
      .beat_take  (line_take),
      .tap        (tap),
      .tap_valid  (tap_valid),
      .tap_ready  (tap_ready)
   );

   tmf_median u_median (
      .clock             (clock),
      .reset             (reset),
      .tap               (tap),
      .tap_valid         (tap_valid),
      .tap_ready         (tap_ready),
      .replace_threshold (replace_threshold_ff),
      .rsp_if            (rsp_if)
   );

   assign eof_shown    = rsp_if.valid && rsp_if.end_of_frame;
   assign row_closed   = rsp_if.end_of_row && rsp_if.last_of_run;
   assign second_taken = line_take && line_beat.has_b;

   `TMF_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_if.valid, "rsp valid after reset")
   `TMF_ASSERT_IMPLY(a_eof_closes_row, clock, reset, eof_shown, row_closed, "eof off row end")
   `TMF_ASSERT_IMPLY(a_row_end_b, clock, reset, second_taken, line_beat.row_end, "no row end")

endmodule

`default_nettype wire
